@@ sv/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: condition must never hold");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/wuf_pkg.sv @@
`timescale 1ns / 1ps

package wuf_pkg;

    localparam int unsigned STAMP_W = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_GSIZE,
        ST_FINISH
    } wuf_state_t;

    typedef struct packed {
        logic link_we;
        logic size_we;
    } wuf_wr_t;

endpackage

@@ sv/wuf_forest.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wuf_forest #(
    parameter int unsigned MAX_ELEMS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wuf_pkg::wuf_wr_t                      wr,
    input  logic [$clog2(MAX_ELEMS)-1:0]          link_raddr,
    input  logic [$clog2(MAX_ELEMS)-1:0]          link_waddr,
    input  logic [$clog2(MAX_ELEMS)-1:0]          link_wdata,
    output logic [$clog2(MAX_ELEMS)-1:0]          link_q,
    input  logic [$clog2(MAX_ELEMS)-1:0]          size_raddr,
    input  logic [$clog2(MAX_ELEMS)-1:0]          size_waddr,
    input  logic [$clog2(MAX_ELEMS):0]            size_wdata,
    output logic [$clog2(MAX_ELEMS):0]            size_q,
    output logic                                  busy
);
    import wuf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMS - 1);

    logic [IDX_W-1:0] link_mem [MAX_ELEMS];
    logic [CNT_W-1:0] size_mem [MAX_ELEMS];

    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] clr_next;
    logic             busy_reg;
    logic             busy_next;

    logic             link_we_int;
    logic [IDX_W-1:0] link_waddr_int;
    logic [IDX_W-1:0] link_wdata_int;
    logic             size_we_int;
    logic [IDX_W-1:0] size_waddr_int;
    logic [CNT_W-1:0] size_wdata_int;

    // clearing sweep after reset: parent of i is i, size is one
    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (clr_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_next = clr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            link_we_int    = 1'b1;
            link_waddr_int = clr_reg;
            link_wdata_int = clr_reg;
            size_we_int    = 1'b1;
            size_waddr_int = clr_reg;
            size_wdata_int = CNT_W'(1);
        end
        else
        begin
            link_we_int    = wr.link_we;
            link_waddr_int = link_waddr;
            link_wdata_int = link_wdata;
            size_we_int    = wr.size_we;
            size_waddr_int = size_waddr;
            size_wdata_int = size_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we_int)
        begin
            link_mem[link_waddr_int] <= link_wdata_int;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we_int)
        begin
            size_mem[size_waddr_int] <= size_wdata_int;
        end
        size_q <= size_mem[size_raddr];
    end

    assign busy = busy_reg;

    `ASSERT_NEVER(a_no_wr_in_clear, clk, rst_n, busy_reg && (wr.link_we || wr.size_we))
    `ASSERT_IMPLY(a_link_not_self, clk, rst_n, !busy_reg && wr.link_we, link_waddr != link_wdata)
    `ASSERT_NEXT(a_clear_once, clk, rst_n, !busy_reg, !busy_reg)

endmodule

@@ sv/weighted_union_find_connectivity.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// weighted quick-union connectivity engine
// input channel (in_valid/in_ready) carries one pair elem_a, elem_b per transfer;
// output channel (out_valid/out_ready) returns one result per pair: merged,
// all_connected, stamp, pair_count, range_error and group_size.
// element_count is to be written through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce it. parent links and tree
// sizes live in two single-port-read memories with a registered read.
// an in-range pair walks from elem_a to its root, then from elem_b to its root,
// one link at a time; differing roots are joined, smaller root under the larger.
// weighted union keeps every tree at most log2(MAX_ELEMS) links deep.
// after reset a clearing pass writes every entry of both memories;
// in_ready stays low until it is done, configuration writes are taken as ever.
// one pair is in flight at a time; in_ready is high only in the idle state.
// the result sits in an output register; a new pair is taken while it waits,
// and the next result is held until out_ready has taken the previous one.
// once one tree covers element_count elements all_connected is sticky and
// later pairs only report the size of elem_a's group.
module weighted_union_find_connectivity #(
    parameter int unsigned MAX_ELEMS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [$clog2(MAX_ELEMS):0]           cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [$clog2(MAX_ELEMS)-1:0]         elem_a,
    input  logic [$clog2(MAX_ELEMS)-1:0]         elem_b,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 merged,
    output logic                                 all_connected,
    output logic [wuf_pkg::STAMP_W-1:0]          stamp,
    output logic [wuf_pkg::STAMP_W-1:0]          pair_count,
    output logic                                 range_error,
    output logic [$clog2(MAX_ELEMS):0]           group_size
);
    import wuf_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMS);
    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);

    wuf_state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   b_reg, b_next;
    logic               b_ok_reg, b_ok_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   ra_reg, ra_next;
    logic [CNT_W-1:0]   sa_reg, sa_next;
    logic               mrg_res_reg, mrg_res_next;
    logic               rerr_res_reg, rerr_res_next;
    logic [CNT_W-1:0]   gsize_res_reg, gsize_res_next;
    logic [STAMP_W-1:0] pair_cnt_reg, pair_cnt_next;
    logic               done_reg, done_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    logic               out_valid_reg, out_valid_next;
    logic               merged_reg, merged_next;
    logic               all_conn_reg, all_conn_next;
    logic [STAMP_W-1:0] stamp_out_reg, stamp_out_next;
    logic [STAMP_W-1:0] pair_out_reg, pair_out_next;
    logic               rerr_out_reg, rerr_out_next;
    logic [CNT_W-1:0]   gsize_out_reg, gsize_out_next;

    logic [CNT_W-1:0]   eff_cnt;
    logic [CNT_W-1:0]   size_sum;

    wuf_wr_t            wr;
    logic [IDX_W-1:0]   link_raddr;
    logic [IDX_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;
    logic [IDX_W-1:0]   link_q;
    logic [IDX_W-1:0]   size_raddr;
    logic [IDX_W-1:0]   size_waddr;
    logic [CNT_W-1:0]   size_wdata;
    logic [CNT_W-1:0]   size_q;
    logic               clr_busy;

    wuf_forest #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_forest (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_q     (link_q),
        .size_raddr (size_raddr),
        .size_waddr (size_waddr),
        .size_wdata (size_wdata),
        .size_q     (size_q),
        .busy       (clr_busy)
    );

    // clamp the configured count into 2..MAX_ELEMS
    always_comb
    begin
        priority if (count_reg < MIN_CNT)
        begin
            eff_cnt = MIN_CNT;
        end
        else if (count_reg > MAX_CNT)
        begin
            eff_cnt = MAX_CNT;
        end
        else
        begin
            eff_cnt = count_reg;
        end
    end

    assign size_sum = sa_reg + size_q;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        b_next         = b_reg;
        b_ok_next      = b_ok_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        sa_next        = sa_reg;
        mrg_res_next   = mrg_res_reg;
        rerr_res_next  = rerr_res_reg;
        gsize_res_next = gsize_res_reg;
        pair_cnt_next  = pair_cnt_reg;
        done_next      = done_reg;
        stamp_next     = stamp_reg;

        out_valid_next = out_valid_reg && !out_ready;
        merged_next    = merged_reg;
        all_conn_next  = all_conn_reg;
        stamp_out_next = stamp_out_reg;
        pair_out_next  = pair_out_reg;
        rerr_out_next  = rerr_out_reg;
        gsize_out_next = gsize_out_reg;

        in_ready   = 1'b0;
        wr         = '0;
        link_raddr = cur_reg;
        link_waddr = ra_reg;
        link_wdata = cur_reg;
        size_raddr = ra_reg;
        size_waddr = ra_reg;
        size_wdata = size_sum;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    b_next    = elem_b;
                    b_ok_next = {1'b0, elem_b} < eff_cnt;
                    if ({1'b0, elem_a} < eff_cnt)
                    begin
                        cur_next   = elem_a;
                        link_raddr = elem_a;
                        state_next = ST_WALK_A;
                    end
                    else
                    begin
                        mrg_res_next   = 1'b0;
                        rerr_res_next  = !done_reg;
                        gsize_res_next = '0;
                        state_next     = ST_FINISH;
                    end
                end
            end

            ST_WALK_A:
            begin
                if (link_q == cur_reg)
                begin
                    ra_next = cur_reg;
                    if (!done_reg && b_ok_reg)
                    begin
                        cur_next   = b_reg;
                        link_raddr = b_reg;
                        state_next = ST_WALK_B;
                    end
                    else
                    begin
                        mrg_res_next  = 1'b0;
                        rerr_res_next = !done_reg;
                        size_raddr    = cur_reg;
                        state_next    = ST_GSIZE;
                    end
                end
                else
                begin
                    cur_next   = link_q;
                    link_raddr = link_q;
                end
            end

            ST_WALK_B:
            begin
                if (link_q == cur_reg)
                begin
                    if (pair_cnt_reg != '1)
                    begin
                        pair_cnt_next = pair_cnt_reg + STAMP_W'(1);
                    end
                    mrg_res_next  = 1'b0;
                    rerr_res_next = 1'b0;
                    size_raddr    = ra_reg;
                    if (ra_reg == cur_reg)
                    begin
                        state_next = ST_GSIZE;
                    end
                    else
                    begin
                        state_next = ST_SIZE_A;
                    end
                end
                else
                begin
                    cur_next   = link_q;
                    link_raddr = link_q;
                end
            end

            ST_SIZE_A:
            begin
                sa_next    = size_q;
                size_raddr = cur_reg;
                state_next = ST_SIZE_B;
            end

            ST_SIZE_B:
            begin
                wr.link_we = 1'b1;
                wr.size_we = 1'b1;
                // tie keeps the root of elem_a on top
                if (size_q > sa_reg)
                begin
                    link_waddr = ra_reg;
                    link_wdata = cur_reg;
                    size_waddr = cur_reg;
                end
                else
                begin
                    link_waddr = cur_reg;
                    link_wdata = ra_reg;
                    size_waddr = ra_reg;
                end
                mrg_res_next   = 1'b1;
                gsize_res_next = size_sum;
                if (size_sum >= eff_cnt)
                begin
                    done_next  = 1'b1;
                    stamp_next = pair_cnt_reg;
                end
                state_next = ST_FINISH;
            end

            ST_GSIZE:
            begin
                gsize_res_next = size_q;
                state_next     = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    merged_next    = mrg_res_reg;
                    all_conn_next  = done_reg;
                    stamp_out_next = done_reg ? stamp_reg : '0;
                    pair_out_next  = pair_cnt_reg;
                    rerr_out_next  = rerr_res_reg;
                    gsize_out_next = gsize_res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= MAX_CNT;
            pair_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pair_cnt_reg  <= pair_cnt_next;
            done_reg      <= done_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg         <= b_next;
        b_ok_reg      <= b_ok_next;
        cur_reg       <= cur_next;
        ra_reg        <= ra_next;
        sa_reg        <= sa_next;
        mrg_res_reg   <= mrg_res_next;
        rerr_res_reg  <= rerr_res_next;
        gsize_res_reg <= gsize_res_next;
        merged_reg    <= merged_next;
        all_conn_reg  <= all_conn_next;
        stamp_out_reg <= stamp_out_next;
        pair_out_reg  <= pair_out_next;
        rerr_out_reg  <= rerr_out_next;
        gsize_out_reg <= gsize_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign merged        = merged_reg;
    assign all_connected = all_conn_reg;
    assign stamp         = stamp_out_reg;
    assign pair_count    = pair_out_reg;
    assign range_error   = rerr_out_reg;
    assign group_size    = gsize_out_reg;

    `ASSERT_NEVER(a_merge_and_rerr, clk, rst_n, out_valid_reg && merged_reg && rerr_out_reg)
    `ASSERT_IMPLY(a_stamp_zero, clk, rst_n, out_valid_reg && !all_conn_reg, stamp_out_reg == '0)
    `ASSERT_NEXT(a_done_sticky, clk, rst_n, done_reg, done_reg)
    `ASSERT_IMPLY(a_ready_after_clear, clk, rst_n, in_ready, !clr_busy)

endmodule

@@ dv/wuf_forest_check.sv @@
`timescale 1ns / 1ps

module wuf_forest_check #(
    parameter int unsigned MAX_ELEMS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [$clog2(MAX_ELEMS):0]     cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [$clog2(MAX_ELEMS)-1:0]   elem_a,
    input  logic [$clog2(MAX_ELEMS)-1:0]   elem_b,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           merged,
    input  logic                           all_connected,
    input  logic [wuf_pkg::STAMP_W-1:0]    stamp,
    input  logic [wuf_pkg::STAMP_W-1:0]    pair_count,
    input  logic                           range_error,
    input  logic [$clog2(MAX_ELEMS):0]     group_size,
    output int                             errors,
    output int                             pending,
    output int                             joins,
    output logic [wuf_pkg::STAMP_W-1:0]    finish_stamp
);

    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMS);

    typedef struct packed {
        logic                          merged;
        logic                          all_connected;
        logic [wuf_pkg::STAMP_W-1:0]   stamp;
        logic [wuf_pkg::STAMP_W-1:0]   pair_count;
        logic                          range_error;
        logic [CNT_W-1:0]              group_size;
    } link_outcome_t;

    logic [IDX_W-1:0]            link_of [MAX_ELEMS];
    logic [CNT_W-1:0]            size_of [MAX_ELEMS];
    logic [wuf_pkg::STAMP_W-1:0] pairs_seen;
    logic                        joined_all;
    logic [wuf_pkg::STAMP_W-1:0] joined_stamp;
    logic [CNT_W-1:0]            elem_total;
    link_outcome_t               results_due [$];

    initial
    begin
        errors = 0;
        pending = 0;
        joins = 0;
        finish_stamp = '0;
    end

    function automatic logic [IDX_W-1:0] root_of(input logic [IDX_W-1:0] x);
        int steps;
        steps = 0;
        while (link_of[x] != x && steps < MAX_ELEMS)
        begin
            x = link_of[x];
            steps++;
        end
        return x;
    endfunction

    // weighted union of one pair, returns the result the block should give
    function automatic link_outcome_t link_pair(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
        link_outcome_t    r;
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        logic [IDX_W-1:0] win;
        logic [IDX_W-1:0] lose;
        logic             a_ok;
        logic             b_ok;
        r = '0;
        if (elem_total < CNT_W'(2))
            n = CNT_W'(2);
        else if (elem_total > CNT_MAX)
            n = CNT_MAX;
        else
            n = elem_total;
        a_ok = {1'b0, a} < n;
        b_ok = {1'b0, b} < n;
        if (!joined_all)
        begin
            if (!a_ok || !b_ok)
                r.range_error = 1'b1;
            else
            begin
                ra = root_of(a);
                rb = root_of(b);
                if (pairs_seen != '1)
                    pairs_seen++;
                if (ra != rb)
                begin
                    win = ra;
                    lose = rb;
                    if (size_of[rb] > size_of[ra])
                    begin
                        win = rb;
                        lose = ra;
                    end
                    link_of[lose] = win;
                    size_of[win] = size_of[win] + size_of[lose];
                    r.merged = 1'b1;
                    joins++;
                    if (size_of[win] >= n)
                    begin
                        joined_all = 1'b1;
                        joined_stamp = pairs_seen;
                        finish_stamp = pairs_seen;
                    end
                end
            end
        end
        if (a_ok)
            r.group_size = size_of[root_of(a)];
        r.all_connected = joined_all;
        r.stamp = joined_all ? joined_stamp : '0;
        r.pair_count = pairs_seen;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ELEMS; i++)
            begin
                link_of[i] = IDX_W'(i);
                size_of[i] = CNT_W'(1);
            end
            pairs_seen = '0;
            joined_all = 1'b0;
            joined_stamp = '0;
            elem_total = CNT_MAX;
            results_due.delete();
        end
        else
        begin
            link_outcome_t want;
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with nothing outstanding", $time);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("merged", 32'(want.merged), 32'(merged));
                    check_field("all_connected", 32'(want.all_connected),
                                32'(all_connected));
                    check_field("stamp", want.stamp, stamp);
                    check_field("pair_count", want.pair_count, pair_count);
                    check_field("range_error", 32'(want.range_error), 32'(range_error));
                    check_field("group_size", 32'(want.group_size), 32'(group_size));
                end
            end
            if (cfg_wr_en)
                elem_total = cfg_wr_data;
            if (in_valid && in_ready)
                results_due.insert(results_due.size(), link_pair(elem_a, elem_b));
        end
        pending = results_due.size();
    end

endmodule

@@ dv/tb_weighted_union_find_connectivity.sv @@
`timescale 1ns / 1ps

module tb_weighted_union_find_connectivity;

    import wuf_pkg::*;

    localparam int MAX_ELEMS = 1024;
    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CNT_W = IDX_W + 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [IDX_W-1:0]   elem_a = '0;
    logic [IDX_W-1:0]   elem_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               merged;
    logic               all_connected;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] pair_count;
    logic               range_error;
    logic [CNT_W-1:0]   group_size;

    int                 errors;
    int                 pending;
    int                 joins;
    logic [STAMP_W-1:0] finish_stamp;
    logic               calm = 1'b0;
    int                 pairs_sent = 0;
    int                 count_writes = 0;

    always #1 clk = ~clk;

    weighted_union_find_connectivity #(
        .MAX_ELEMS(MAX_ELEMS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .elem_a(elem_a),
        .elem_b(elem_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .merged(merged),
        .all_connected(all_connected),
        .stamp(stamp),
        .pair_count(pair_count),
        .range_error(range_error),
        .group_size(group_size)
    );

    wuf_forest_check #(
        .MAX_ELEMS(MAX_ELEMS)
    ) forest_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .elem_a(elem_a),
        .elem_b(elem_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .merged(merged),
        .all_connected(all_connected),
        .stamp(stamp),
        .pair_count(pair_count),
        .range_error(range_error),
        .group_size(group_size),
        .errors(errors),
        .pending(pending),
        .joins(joins),
        .finish_stamp(finish_stamp)
    );

    // result side stalls about 15 percent of cycles
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 15);

    task automatic offer_pair(input int a, input int b);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elem_a <= IDX_W'(a);
        elem_b <= IDX_W'(b);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        pairs_sent++;
    endtask

    // only while idle: every outstanding result has come back
    task automatic set_count(input int value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        count_writes++;
    endtask

    // one pair with at least one index at or above the count
    task automatic offer_stray(input int lo);
        int inr;
        int outr;
        inr = $urandom_range(0, MAX_ELEMS - 1);
        outr = $urandom_range(lo, MAX_ELEMS - 1);
        if ($urandom_range(0, 1))
            offer_pair(inr, outr);
        else
            offer_pair(outr, inr);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // count below the floor acts as two
        set_count(0);
        offer_pair(0, 0);
        offer_pair(1, 1);
        offer_pair(2, 0);
        offer_pair(1023, 1023);
        offer_pair(1, 2);
        set_count(2);
        offer_pair(1, 1);
        offer_pair(0, 1023);

        // small forest, trees kept below the count
        set_count(40);
        offer_pair(3, 4);
        offer_pair(5, 3);
        offer_pair(4, 5);
        offer_pair(8, 9);
        offer_pair(10, 11);
        offer_pair(8, 10);
        offer_pair(3, 8);
        offer_pair(19, 0);
        offer_pair(39, 40);
        offer_pair(40, 39);
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 99) < 80)
                offer_pair($urandom_range(0, 19), $urandom_range(0, 19));
            else
                offer_stray(40);
        end

        // count above the ceiling acts as the maximum
        set_count(2047);
        offer_pair(1023, 0);
        offer_pair(0, 1023);
        offer_pair(1023, 1022);
        offer_pair(512, 511);
        offer_pair(682, 341);

        set_count(MAX_ELEMS);
        for (int i = 0; i < 450; i++)
        begin
            calm = (i >= 150 && i < 400);
            offer_pair($urandom_range(0, MAX_ELEMS - 1), $urandom_range(0, MAX_ELEMS - 1));
        end
        calm = 1'b0;

        // chain every element below the count into one tree
        set_count(1000);
        for (int k = 1; k < 1000; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                offer_stray(1000);
            if ($urandom_range(0, 1))
                offer_pair(k, $urandom_range(0, k - 1));
            else
                offer_pair($urandom_range(0, k - 1), k);
        end

        // after completion every pair is ignored
        for (int i = 0; i < 20; i++)
            offer_pair($urandom_range(0, MAX_ELEMS - 1), $urandom_range(0, MAX_ELEMS - 1));
        set_count(4);
        for (int i = 0; i < 15; i++)
            offer_pair($urandom_range(0, MAX_ELEMS - 1), $urandom_range(0, 7));

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("sent %0d pairs under %0d element-count writes, %0d joins",
                 pairs_sent, count_writes, joins);
        $display("full connectivity reached at pair %0d", finish_stamp);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/wuf_pkg.sv
sv/wuf_forest.sv
sv/weighted_union_find_connectivity.sv
dv/wuf_forest_check.sv
dv/tb_weighted_union_find_connectivity.sv
